@@ hw/rtl/ttsm_pkg.sv @@
// ----------------------------------------------------------------------------
// ttsm_pkg
// Shared types and codes for the task timeout and stall monitor.
// ----------------------------------------------------------------------------
package ttsm_pkg;

	localparam int MAX_TASKS_DEF = 64;
	localparam int RES_CAP       = 64;

	localparam logic [15:0] ALERT_RST = 16'd60;
	localparam logic [15:0] FAIL_RST  = 16'd90;
	localparam logic [15:0] STALL_RST = 16'd10;

	localparam logic [2:0] CMD_START   = 3'd0;
	localparam logic [2:0] CMD_SUCCESS = 3'd1;
	localparam logic [2:0] CMD_FAILURE = 3'd2;
	localparam logic [2:0] CMD_TICK    = 3'd3;
	localparam logic [2:0] CMD_STARVE  = 3'd4;
	localparam logic [2:0] CMD_DEADLK  = 3'd5;
	localparam logic [2:0] CMD_METRICS = 3'd6;

	localparam logic [2:0] KIND_ACK     = 3'd0;
	localparam logic [2:0] KIND_ALERT   = 3'd1;
	localparam logic [2:0] KIND_FAIL    = 3'd2;
	localparam logic [2:0] KIND_DEADLK  = 3'd3;
	localparam logic [2:0] KIND_METRICS = 3'd4;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;

	localparam logic [1:0] REG_ALERT = 2'd0;
	localparam logic [1:0] REG_FAIL  = 2'd1;
	localparam logic [1:0] REG_STALL = 2'd2;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] start;
		logic [1:0]  state;
	} entry_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic        rejected;
		logic [15:0] task_id;
		logic [31:0] idle;
		logic [6:0]  running;
		logic [6:0]  total;
		logic [6:0]  ok;
		logic [6:0]  bad;
		logic [31:0] dl;
	} res_t;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RD    = 7'b0000010,
		S_EV    = 7'b0000100,
		S_SRD   = 7'b0001000,
		S_SEV   = 7'b0010000,
		S_FIN   = 7'b0100000,
		S_FLUSH = 7'b1000000
	} state_t;

	typedef struct packed {
		logic accept;
		logic rd;
		logic ev;
		logic srd;
		logic sev;
		logic fin;
		logic flush;
	} ctl_t;

	typedef struct packed {
		logic start_search;
		logic start_walk;
		logic walk_empty;
		logic ev_wait;
		logic ev_search;
		logic walk_last;
		logic s_done;
		logic in_walk;
		logic out_free;
	} sts_t;

endpackage

@@ hw/rtl/ttsm_ram.sv @@
// ----------------------------------------------------------------------------
// ttsm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ttsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/ttsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ttsm_ctrl
// Sequencer: accepts an item, steps table walks and searches, flushes results.
// ----------------------------------------------------------------------------
module ttsm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ttsm_pkg::sts_t  sts,
	output ttsm_pkg::ctl_t  ctl
);
	import ttsm_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (sts.start_search)    state_d = S_SRD;
					else if (sts.start_walk) state_d = S_RD;
					else if (sts.walk_empty) state_d = S_FIN;
					else                     state_d = S_FLUSH;
				end
			end
			S_RD: state_d = S_EV;
			S_EV: begin
				if (!sts.ev_wait) begin
					if (sts.ev_search)      state_d = S_SRD;
					else if (sts.walk_last) state_d = S_FIN;
					else                    state_d = S_RD;
				end
			end
			S_SRD: state_d = S_SEV;
			S_SEV: begin
				if (sts.s_done) begin
					if (!sts.in_walk)       state_d = S_FLUSH;
					else if (sts.walk_last) state_d = S_FIN;
					else                    state_d = S_RD;
				end else begin
					state_d = S_SRD;
				end
			end
			S_FIN: state_d = S_FLUSH;
			S_FLUSH: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign in_stall   = (state_q != S_IDLE);
	assign ctl.accept = (state_q == S_IDLE) && in_valid;
	assign ctl.rd     = (state_q == S_RD);
	assign ctl.ev     = (state_q == S_EV);
	assign ctl.srd    = (state_q == S_SRD);
	assign ctl.sev    = (state_q == S_SEV);
	assign ctl.fin    = (state_q == S_FIN);
	assign ctl.flush  = (state_q == S_FLUSH);

endmodule

@@ hw/rtl/ttsm_dp.sv @@
// ----------------------------------------------------------------------------
// ttsm_dp
// Datapath: task table, clocks, counters, pending result and output register.
// ----------------------------------------------------------------------------
module ttsm_dp #(
	parameter int MAX_TASKS = ttsm_pkg::MAX_TASKS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     cmd,
	input  logic [15:0]    task_id,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_addr,
	input  logic [15:0]    cfg_data,
	input  ttsm_pkg::ctl_t ctl,
	output ttsm_pkg::sts_t sts,
	output logic           out_valid,
	input  logic           out_stall,
	output ttsm_pkg::res_t out_res,
	output logic           last
);
	import ttsm_pkg::*;

	localparam int AW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int EW = $bits(entry_t);

	logic [15:0]   alert_q, fail_q, stall_q;
	logic [2:0]    cmd_q;
	logic [15:0]   tid_q;
	logic [1:0]    mark_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q, sidx_q;
	logic [31:0]   now_q, last_ev_q, dl_q;
	logic [CW-1:0] run_q, ok_q, bad_q;
	logic [6:0]    n_q;
	res_t          pend_q;
	logic          pend_valid_q;
	res_t          out_q;
	logic          out_valid_q, last_q;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, rd;

	logic          full, run, fail_hit, alert_hit, emit, out_free, push, s_match;
	logic          dl_hit;
	logic [31:0]   wait_s, idle_s;
	res_t          push_res;
	logic          push_last;
	res_t          acc_res, emit_res, fin_res;

	assign full      = (count_q == CW'(MAX_TASKS));
	assign run       = (rd.state == ST_RUN);
	assign wait_s    = now_q - rd.start;
	assign idle_s    = now_q - last_ev_q;
	assign fail_hit  = run && (wait_s >= {16'd0, fail_q});
	assign alert_hit = run && !fail_hit && (wait_s >= {16'd0, alert_q});
	assign emit      = (cmd_q == CMD_STARVE) && (fail_hit || alert_hit)
	                   && (n_q < 7'(RES_CAP));
	assign out_free  = !out_valid_q || !out_stall;
	assign s_match   = (rd.id == tid_q);
	assign dl_hit    = (idle_s >= {16'd0, stall_q}) && (run_q != '0);

	assign sts.start_search = ((cmd == CMD_SUCCESS) || (cmd == CMD_FAILURE))
	                          && (count_q != '0);
	assign sts.start_walk   = ((cmd == CMD_STARVE) || (cmd == CMD_DEADLK)
	                          || (cmd == CMD_METRICS)) && (count_q != '0);
	assign sts.walk_empty   = ((cmd == CMD_STARVE) || (cmd == CMD_DEADLK)
	                          || (cmd == CMD_METRICS)) && (count_q == '0);
	assign sts.ev_wait      = emit && pend_valid_q && !out_free;
	assign sts.ev_search    = (cmd_q == CMD_STARVE) && fail_hit;
	assign sts.walk_last    = (CW'(idx_q) + CW'(1) == count_q);
	assign sts.s_done       = s_match || (CW'(sidx_q) + CW'(1) == count_q);
	assign sts.in_walk      = (cmd_q == CMD_STARVE);
	assign sts.out_free     = out_free;

	// the output register takes a result in an emit or in the final flush
	assign push      = (ctl.ev && emit && pend_valid_q && out_free)
	                   || (ctl.flush && out_free);
	assign push_res  = pend_q;
	assign push_last = ctl.flush;

	// result words loaded into the pending register
	always_comb begin
		acc_res          = '0;
		acc_res.rejected = (cmd == CMD_START) && full;
		emit_res         = '0;
		emit_res.kind    = fail_hit ? KIND_FAIL : KIND_ALERT;
		emit_res.task_id = rd.id;
		fin_res          = '0;
		case (cmd_q)
			CMD_DEADLK: begin
				if (dl_hit) begin
					fin_res.kind    = KIND_DEADLK;
					fin_res.idle    = idle_s;
					fin_res.running = 7'(run_q);
				end
			end
			CMD_METRICS: begin
				fin_res.kind  = KIND_METRICS;
				fin_res.total = 7'(count_q);
				fin_res.ok    = 7'(ok_q);
				fin_res.bad   = 7'(bad_q);
				fin_res.dl    = dl_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(count_q);
		ram_wdata = '{id: task_id, start: now_q, state: ST_RUN};
		if (ctl.accept && (cmd == CMD_START) && !full) begin
			ram_we = 1'b1;
		end else if (ctl.sev && s_match) begin
			ram_we    = 1'b1;
			ram_waddr = sidx_q;
			ram_wdata = '{id: rd.id, start: rd.start, state: mark_q};
		end
	end

	assign ram_re    = ctl.rd || ctl.srd;
	assign ram_raddr = ctl.srd ? sidx_q : idx_q;

	ttsm_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_tab (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alert_q      <= ALERT_RST;
			fail_q       <= FAIL_RST;
			stall_q      <= STALL_RST;
			cmd_q        <= CMD_TICK;
			tid_q        <= '0;
			mark_q       <= ST_RUN;
			count_q      <= '0;
			idx_q        <= '0;
			sidx_q       <= '0;
			now_q        <= '0;
			last_ev_q    <= '0;
			dl_q         <= '0;
			run_q        <= '0;
			ok_q         <= '0;
			bad_q        <= '0;
			n_q          <= '0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_ALERT: alert_q <= cfg_data;
					REG_FAIL:  fail_q  <= cfg_data;
					REG_STALL: stall_q <= cfg_data;
					default: ;
				endcase
			end

			if (push) begin
				out_q       <= push_res;
				last_q      <= push_last;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (ctl.accept) begin
				cmd_q        <= cmd;
				tid_q        <= task_id;
				mark_q       <= (cmd == CMD_SUCCESS) ? ST_OK : ST_FAIL;
				idx_q        <= '0;
				sidx_q       <= '0;
				run_q        <= '0;
				ok_q         <= '0;
				bad_q        <= '0;
				n_q          <= '0;
				pend_q       <= acc_res;
				pend_valid_q <= !sts.start_walk && !sts.walk_empty;
				case (cmd)
					CMD_START: begin
						if (!full) begin
							count_q   <= count_q + CW'(1);
							last_ev_q <= now_q;
						end
					end
					CMD_SUCCESS, CMD_FAILURE: last_ev_q <= now_q;
					CMD_TICK:                 now_q     <= now_q + 32'd1;
					default: ;
				endcase
			end

			if (ctl.ev && !sts.ev_wait) begin
				case (cmd_q)
					CMD_DEADLK:  if (run) run_q <= run_q + CW'(1);
					CMD_METRICS: begin
						if (rd.state == ST_OK)   ok_q  <= ok_q + CW'(1);
						if (rd.state == ST_FAIL) bad_q <= bad_q + CW'(1);
					end
					default: ;
				endcase
				if (emit) begin
					pend_q       <= emit_res;
					pend_valid_q <= 1'b1;
					n_q          <= n_q + 7'd1;
				end
				if (sts.ev_search) begin
					tid_q     <= rd.id;
					mark_q    <= ST_FAIL;
					sidx_q    <= '0;
					last_ev_q <= now_q;
				end else begin
					idx_q <= idx_q + AW'(1);
				end
			end

			if (ctl.sev) begin
				if (sts.s_done) begin
					if (cmd_q == CMD_STARVE) idx_q <= idx_q + AW'(1);
				end else begin
					sidx_q <= sidx_q + AW'(1);
				end
			end

			if (ctl.fin) begin
				pend_valid_q <= 1'b1;
				case (cmd_q)
					CMD_STARVE: if (!pend_valid_q) pend_q <= '0;
					CMD_DEADLK: begin
						pend_q <= fin_res;
						if (dl_hit) begin
							last_ev_q <= now_q;
							if (dl_q != 32'hFFFF_FFFF) dl_q <= dl_q + 32'd1;
						end
					end
					CMD_METRICS: pend_q <= fin_res;
					default:     pend_q <= '0;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign last      = last_q;

endmodule

@@ hw/rtl/task_timeout_and_stall_monitor.sv @@
// ----------------------------------------------------------------------------
// task_timeout_and_stall_monitor
// Task table with starvation, deadlock and metrics reporting.
// ----------------------------------------------------------------------------
// Start, tick and unused codes go from idle to the flush. Success and failure
// search the table from the top, a read and an evaluate state per entry up to
// the first match or the last entry (table RAM with one write port and one
// registered read port), then flush. Starvation, deadlock and metrics checks
// walk every entry alike, plus a search for each task that a starvation check
// fails, then finish and flush; results leave through one output register, so
// a stalled output holds the walk. One item is in work at a time.
module task_timeout_and_stall_monitor #(
	parameter int MAX_TASKS = ttsm_pkg::MAX_TASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [15:0] task_id,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic        rejected,
	output logic [15:0] flagged_task,
	output logic [31:0] idle_seconds,
	output logic [6:0]  running_count,
	output logic [6:0]  total_count,
	output logic [6:0]  success_count,
	output logic [6:0]  failure_count,
	output logic [31:0] deadlock_total,
	output logic        last
);
	import ttsm_pkg::*;

	ctl_t ctl;
	sts_t sts;
	res_t res;

	ttsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	ttsm_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.task_id   (task_id),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res),
		.last      (last)
	);

	assign kind           = res.kind;
	assign rejected       = res.rejected;
	assign flagged_task   = res.task_id;
	assign idle_seconds   = res.idle;
	assign running_count  = res.running;
	assign total_count    = res.total;
	assign success_count  = res.ok;
	assign failure_count  = res.bad;
	assign deadlock_total = res.dl;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the task timeout and stall monitor: directed and
// random command items with random idling on both channels, results checked
// field by field against a behavioral predictor of the task table.
// ----------------------------------------------------------------------------
module tb_top;
	import ttsm_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] id;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic        rejected;
		logic [15:0] task_id;
		logic [31:0] idle;
		logic [6:0]  running;
		logic [6:0]  total;
		logic [6:0]  ok;
		logic [6:0]  bad;
		logic [31:0] dl;
		logic        last;
	} report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd = '0;
	logic [15:0] task_id = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [15:0] cfg_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic        rejected;
	logic [15:0] flagged_task;
	logic [31:0] idle_seconds;
	logic [6:0]  running_count;
	logic [6:0]  total_count;
	logic [6:0]  success_count;
	logic [6:0]  failure_count;
	logic [31:0] deadlock_total;
	logic        last;

	task_timeout_and_stall_monitor DUT (.*);

	always #6 clk = ~clk;

	// predictor state
	logic [15:0] tbl_id [TABLE_DEPTH];
	logic [31:0] tbl_start [TABLE_DEPTH];
	logic [1:0]  tbl_state [TABLE_DEPTH];
	int unsigned tbl_count;
	logic [31:0] now_sec, last_event, deadlocks;
	logic [15:0] alert_to, fail_to, stall_to;

	cmd_item_t pending_cmds [$];
	report_t   expected_reports [$];
	int        errors = 0;
	int        items_sent = 0;
	int        reports_seen = 0;
	int        alerts_seen = 0;
	int        idle_cycles = 0;
	bit        hold_off = 1'b0;
	int        send_gap = 0;
	int        recv_gap = 0;

	function automatic report_t blank_report(logic [2:0] k);
		report_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	function automatic void mark_task(logic [15:0] id, logic [1:0] st);
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_id[i] == id) begin
				tbl_state[i] = st;
				break;
			end
		end
		last_event = now_sec;
	endfunction

	function automatic void predict_reports(cmd_item_t it);
		report_t r;
		report_t batch [$];
		logic [31:0] waited;
		int unsigned runs, oks, bads;
		case (it.cmd)
			CMD_START: begin
				r = blank_report(KIND_ACK);
				if (tbl_count < TABLE_DEPTH) begin
					tbl_id[tbl_count] = it.id;
					tbl_start[tbl_count] = now_sec;
					tbl_state[tbl_count] = ST_RUN;
					tbl_count++;
					last_event = now_sec;
				end else begin
					r.rejected = 1'b1;
				end
				batch.push_back(r);
			end
			CMD_SUCCESS, CMD_FAILURE: begin
				mark_task(it.id, it.cmd == CMD_SUCCESS ? ST_OK : ST_FAIL);
				batch.push_back(blank_report(KIND_ACK));
			end
			CMD_TICK: begin
				now_sec++;
				batch.push_back(blank_report(KIND_ACK));
			end
			CMD_STARVE: begin
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_state[i] != ST_RUN) continue;
					waited = now_sec - tbl_start[i];
					if (waited >= fail_to) begin
						r = blank_report(KIND_FAIL);
						r.task_id = tbl_id[i];
						if (batch.size() < RES_CAP) batch.push_back(r);
						mark_task(tbl_id[i], ST_FAIL);
					end else if (waited >= alert_to) begin
						r = blank_report(KIND_ALERT);
						r.task_id = tbl_id[i];
						if (batch.size() < RES_CAP) batch.push_back(r);
					end
				end
				if (batch.size() == 0) batch.push_back(blank_report(KIND_ACK));
			end
			CMD_DEADLK: begin
				runs = 0;
				for (int i = 0; i < tbl_count; i++)
					if (tbl_state[i] == ST_RUN) runs++;
				if ((now_sec - last_event) >= stall_to && runs > 0) begin
					if (deadlocks != 32'hFFFF_FFFF) deadlocks++;
					r = blank_report(KIND_DEADLK);
					r.idle = now_sec - last_event;
					r.running = 7'(runs);
					last_event = now_sec;
				end else begin
					r = blank_report(KIND_ACK);
				end
				batch.push_back(r);
			end
			CMD_METRICS: begin
				oks = 0;
				bads = 0;
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_state[i] == ST_OK) oks++;
					if (tbl_state[i] == ST_FAIL) bads++;
				end
				r = blank_report(KIND_METRICS);
				r.total = 7'(tbl_count);
				r.ok = 7'(oks);
				r.bad = 7'(bads);
				r.dl = deadlocks;
				batch.push_back(r);
			end
			default: batch.push_back(blank_report(KIND_ACK));
		endcase
		batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k]) expected_reports.push_back(batch[k]);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				items_sent <= items_sent + 1;
				send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
				if (pending_cmds.size() > 0 && $urandom_range(0, 3) == 0) begin
					cmd <= pending_cmds[0].cmd;
					task_id <= pending_cmds[0].id;
					predict_reports(pending_cmds.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end else if (!in_valid && pending_cmds.size() > 0) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else begin
					in_valid <= 1'b1;
					cmd <= pending_cmds[0].cmd;
					task_id <= pending_cmds[0].id;
					predict_reports(pending_cmds.pop_front());
				end
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk) begin
		report_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {kind, rejected, flagged_task, idle_seconds, running_count,
					total_count, success_count, failure_count, deadlock_total, last};
				reports_seen <= reports_seen + 1;
				if (kind == KIND_ALERT || kind == KIND_FAIL) alerts_seen <= alerts_seen + 1;
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected result %p", $time, got);
					errors <= errors + 1;
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
						errors <= errors + 1;
					end
				end
				recv_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
				out_stall <= hold_off || $urandom_range(0, 1);
			end else if (hold_off) begin
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				expected_reports.size());
			$display("** task_timeout_and_stall_monitor: FAILED **");
			$finish;
		end
	end

	task automatic add_cmd(logic [2:0] c, logic [15:0] id);
		pending_cmds.push_back('{cmd: c, id: id});
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || in_valid || expected_reports.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ALERT: alert_to = val;
			REG_FAIL:  fail_to = val;
			REG_STALL: stall_to = val;
			default: ;
		endcase
	endtask

	// random burst: starts, ticks, completions, checks and random codes
	task automatic random_burst(int count, int max_tick);
		logic [15:0] ids [$];
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 19);
			if (r < 5) begin
				ids.push_back($urandom_range(0, 3) == 0 ? 16'($urandom)
					: 16'($urandom_range(0, 15)));
				add_cmd(CMD_START, ids[$]);
			end else if (r < 9) begin
				repeat ($urandom_range(1, max_tick)) add_cmd(CMD_TICK, 16'($urandom));
			end else if (r < 12 && ids.size() > 0) begin
				add_cmd($urandom_range(0, 1) ? CMD_SUCCESS : CMD_FAILURE,
					ids[$urandom_range(0, ids.size() - 1)]);
			end else if (r < 15) begin
				add_cmd(CMD_STARVE, 16'($urandom));
			end else if (r < 17) begin
				add_cmd(CMD_DEADLK, 16'($urandom));
			end else if (r < 19) begin
				add_cmd(CMD_METRICS, 16'($urandom));
			end else begin
				add_cmd(3'($urandom_range(0, 7)), 16'($urandom));
			end
		end
	endtask

	initial begin
		tbl_count = 0;
		now_sec = '0;
		last_event = '0;
		deadlocks = '0;
		alert_to = ALERT_RST;
		fail_to = FAIL_RST;
		stall_to = STALL_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: id extremes, every code, unmatched id, both thresholds
		write_reg(REG_ALERT, 16'd2);
		write_reg(REG_FAIL, 16'd4);
		write_reg(REG_STALL, 16'd1);
		write_reg(REG_NONE, 16'hFFFF);
		add_cmd(CMD_METRICS, 16'h0000);
		add_cmd(CMD_DEADLK, 16'h0000);
		add_cmd(CMD_START, 16'h0000);
		add_cmd(CMD_START, 16'hFFFF);
		add_cmd(CMD_START, 16'hFFFF);
		add_cmd(CMD_SUCCESS, 16'h1234);
		add_cmd(CMD_STARVE, 16'h0000);
		add_cmd(CMD_TICK, 16'h0000);
		add_cmd(CMD_TICK, 16'hFFFF);
		add_cmd(CMD_STARVE, 16'h0000);
		add_cmd(CMD_DEADLK, 16'h0000);
		add_cmd(CMD_TICK, 16'h0000);
		add_cmd(CMD_TICK, 16'h0000);
		add_cmd(CMD_STARVE, 16'h0000);
		add_cmd(CMD_SUCCESS, 16'hFFFF);
		add_cmd(CMD_FAILURE, 16'h0000);
		add_cmd(CMD_UNUSED, 16'hA5A5);
		add_cmd(CMD_METRICS, 16'h5A5A);
		drain();

		// zero thresholds: everything running fails at once
		write_reg(REG_ALERT, 16'd0);
		write_reg(REG_FAIL, 16'd0);
		write_reg(REG_STALL, 16'd0);
		add_cmd(CMD_START, 16'h0042);
		add_cmd(CMD_DEADLK, 16'h0000);
		add_cmd(CMD_STARVE, 16'h0000);
		add_cmd(CMD_METRICS, 16'h0000);
		drain();

		// fill the table past full while the receiver holds off
		write_reg(REG_ALERT, 16'd3);
		write_reg(REG_FAIL, 16'd6);
		write_reg(REG_STALL, 16'd2);
		hold_off = 1'b1;
		for (int i = tbl_count; i < TABLE_DEPTH + 2; i++) add_cmd(CMD_START, 16'($urandom));
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
		repeat (5) add_cmd(CMD_TICK, 16'h0);
		add_cmd(CMD_STARVE, 16'h0);
		add_cmd(CMD_METRICS, 16'h0);
		drain();

		// the table is full now: random traffic exercises checks on a full table
		random_burst(6, 4);
		drain();

		write_reg(REG_ALERT, 16'hFFFF);
		write_reg(REG_FAIL, 16'hFFFF);
		write_reg(REG_STALL, 16'hFFFF);
		random_burst(6, 3);
		drain();

		write_reg(REG_ALERT, 16'd1);
		write_reg(REG_FAIL, 16'd3);
		write_reg(REG_STALL, 16'd3);
		random_burst(6, 3);
		drain();

		$display("Sent %0d items, checked %0d results (%0d alerts or failures).",
			items_sent, reports_seen, alerts_seen);
		$display("Covered empty and full table, zero and maximum thresholds, input backpressure.");
		if (errors == 0 && expected_reports.size() == 0) begin
			$display("** task_timeout_and_stall_monitor: PASSED **");
		end else begin
			$display("** task_timeout_and_stall_monitor: FAILED **");
		end
		$finish;
	end

endmodule
